// ----- rtl/core/fixed_block_pool_allocator_macros.svh -----
// Assertion macros for the block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FBPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fbpa_pkg.sv -----
// Shared types, codes and helpers of the block pool allocator
`default_nettype none
package fbpa_pkg;

  localparam int DEF_NUM_BLOCKS = 256;
  localparam int MAX_LINK_DEPTH = 256;

  localparam logic [12:0] SIZE_RESET  = 13'd64;
  localparam logic [12:0] SIZE_LIMIT  = 13'd4096;
  localparam logic [8:0]  COUNT_RESET = 9'd256;
  localparam logic [8:0]  COUNT_LIMIT = 9'd256;

  // register index, taken from paddr[2]
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_RESET = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  typedef struct packed {
    logic [12:0] eff_size;
    logic [8:0]  block_count;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  block_index;
    logic [19:0] byte_offset;
    logic [8:0]  blocks_in_use;
  } res_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [12:0] eff_size(input logic [12:0] size);
    logic [12:0] r;
    if (size == 13'd0) begin
      r = 13'd1;
    end else if (size > SIZE_LIMIT) begin
      r = SIZE_LIMIT;
    end else begin
      r = size;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fbpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module fbpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/fbpa_core.sv -----
// Free-list sequencer: head pointer, use count, link memory and result register
`default_nettype none
module fbpa_core #(
  parameter int NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fbpa_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_mode,
  input  wire logic [15:0]     in_request_size,
  input  wire logic [7:0]      in_free_index,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output fbpa_pkg::res_t       out_res
);

  localparam int DEPTH = (NUM_BLOCKS < fbpa_pkg::MAX_LINK_DEPTH) ?
                         NUM_BLOCKS : fbpa_pkg::MAX_LINK_DEPTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = AW + 1;
  localparam logic [8:0] DEPTH9 = 9'(DEPTH);
  localparam logic [8:0] RESET_POOL = (fbpa_pkg::COUNT_RESET > DEPTH9) ?
                                      DEPTH9 : fbpa_pkg::COUNT_RESET;

  typedef enum logic [1:0] {S_LINK, S_IDLE, S_POP, S_RESP} state_t;

  state_t          state_r;
  logic [AW-1:0]   sweep_r;
  logic [8:0]      pool_n_r;
  logic            pool_rst_r;
  logic [AW-1:0]   head_r;
  logic            head_valid_r;
  logic [8:0]      count_r;
  logic            out_valid_r;
  fbpa_pkg::res_t  out_res_r;
  fbpa_pkg::res_t  res_r;

  fbpa_pkg::mode_t mode;
  logic            acc;
  logic            too_big;
  logic            head_ok;
  logic            free_ok;
  logic            out_free;
  logic [8:0]      sweep_nx;
  logic            last;
  logic [8:0]      clamp_n;
  logic [8:0]      count_inc;
  logic [8:0]      count_dec;
  logic [7:0]      mul_idx;
  logic [20:0]     prod;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [LW-1:0]   ram_wdata;
  logic            ram_re;
  logic [LW-1:0]   ram_rdata;
  logic            fin_valid;
  fbpa_pkg::res_t  fin;
  state_t          fin_state;

  assign mode      = fbpa_pkg::mode_t'(in_mode);
  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign too_big   = in_request_size > 16'(cfg.eff_size);
  assign head_ok   = head_valid_r && (9'(head_r) < pool_n_r);
  assign free_ok   = 9'(in_free_index) < pool_n_r;
  assign out_free  = !out_valid_r || out_ready;
  assign fin_state = out_free ? S_IDLE : S_RESP;
  assign sweep_nx  = 9'(sweep_r) + 9'd1;
  assign last      = (sweep_nx == pool_n_r);
  assign count_inc = (count_r == fbpa_pkg::COUNT_LIMIT) ? count_r : count_r + 9'd1;
  assign count_dec = (count_r == 9'd0) ? count_r : count_r - 9'd1;

  always_comb begin
    if (cfg.block_count == 9'd0) begin
      clamp_n = 9'd1;
    end else if (cfg.block_count > DEPTH9) begin
      clamp_n = DEPTH9;
    end else begin
      clamp_n = cfg.block_count;
    end
  end

  // one offset multiplier, shared by the free path and the pop
  assign mul_idx = (state_r == S_POP) ? 8'(head_r) : in_free_index;
  assign prod    = 21'(mul_idx) * 21'(cfg.eff_size);

  // writes happen only in the sweep or at a free accept, reads only at an
  // allocate accept, so a read never meets a write to the same entry
  assign ram_we    = (state_r == S_LINK) || (acc && mode == fbpa_pkg::MODE_FREE && free_ok);
  assign ram_waddr = (state_r == S_LINK) ? sweep_r : in_free_index[AW-1:0];
  assign ram_wdata = (state_r == S_LINK) ? {sweep_nx < pool_n_r, sweep_nx[AW-1:0]}
                                         : {head_valid_r, head_r};
  assign ram_re    = acc && mode == fbpa_pkg::MODE_ALLOC && !too_big && head_ok;

  fbpa_ram #(
    .WIDTH (LW),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    fin_valid = 1'b0;
    fin       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (mode)
            fbpa_pkg::MODE_ALLOC: begin
              fin.blocks_in_use = count_r;
              if (too_big) begin
                fin_valid  = 1'b1;
                fin.status = fbpa_pkg::ST_TOO_BIG;
              end else if (!head_ok) begin
                fin_valid  = 1'b1;
                fin.status = fbpa_pkg::ST_EMPTY;
              end
            end
            fbpa_pkg::MODE_FREE: begin
              fin_valid         = 1'b1;
              fin.block_index   = in_free_index;
              fin.byte_offset   = prod[19:0];
              fin.blocks_in_use = free_ok ? count_dec : count_r;
            end
            fbpa_pkg::MODE_RESET: begin
              fin_valid = 1'b0;
            end
            fbpa_pkg::MODE_NOP: begin
              fin_valid         = 1'b1;
              fin.blocks_in_use = count_r;
            end
            default: begin
              fin_valid = 1'b0;
            end
          endcase
        end
      end
      S_POP: begin
        fin_valid         = 1'b1;
        fin.block_index   = 8'(head_r);
        fin.byte_offset   = prod[19:0];
        fin.blocks_in_use = count_inc;
      end
      S_LINK: begin
        fin_valid = last && pool_rst_r;
      end
      S_RESP: begin
        fin_valid = 1'b0;
      end
      default: begin
        fin_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LINK;
      sweep_r      <= '0;
      pool_n_r     <= RESET_POOL;
      pool_rst_r   <= 1'b0;
      head_r       <= '0;
      head_valid_r <= 1'b1;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // deliver a finished or parked item, else drop the one just taken
      if (fin_valid && out_free) begin
        out_valid_r <= 1'b1;
        out_res_r   <= fin;
      end else if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // park a finished item until the output frees up
      if (fin_valid && !out_free) begin
        res_r <= fin;
      end
      unique case (state_r)
        S_LINK: begin
          sweep_r <= last ? '0 : sweep_nx[AW-1:0];
          if (last) begin
            head_r       <= '0;
            head_valid_r <= 1'b1;
            count_r      <= '0;
            pool_rst_r   <= 1'b0;
            state_r      <= fin_valid ? fin_state : S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            unique case (mode)
              fbpa_pkg::MODE_ALLOC: begin
                state_r <= fin_valid ? fin_state : S_POP;
              end
              fbpa_pkg::MODE_FREE: begin
                if (free_ok) begin
                  head_r       <= in_free_index[AW-1:0];
                  head_valid_r <= 1'b1;
                end
                count_r <= fin.blocks_in_use;
                state_r <= fin_state;
              end
              fbpa_pkg::MODE_RESET: begin
                pool_n_r   <= clamp_n;
                pool_rst_r <= 1'b1;
                sweep_r    <= '0;
                state_r    <= S_LINK;
              end
              fbpa_pkg::MODE_NOP: begin
                state_r <= fin_state;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_POP: begin
          // advance head to the popped block's successor
          head_r       <= ram_rdata[AW-1:0];
          head_valid_r <= ram_rdata[AW];
          count_r      <= fin.blocks_in_use;
          state_r      <= fin_state;
        end
        S_RESP: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

// ----- rtl/core/fixed_block_pool_allocator.sv -----
// Allocate: the result is registered from the pop state; free, failed allocate, mode 3: from the accept.
// An item is taken every cycle the sequencer idles; a pop waits on the link RAM read.
// Pool reset: the link RAM is rewritten one entry a cycle; the result comes with the last entry.
// After rst_n (synchronous, active low) the same relink runs over min(NUM_BLOCKS, 256)
// entries with in_ready low; config writes are taken throughout.
// Config registers reset to block_size 64 and block_count 256.
`default_nettype none
`include "fixed_block_pool_allocator_macros.svh"
module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_request_size,
  input  wire logic [7:0]  in_free_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_block_index,
  output logic [19:0]      out_byte_offset,
  output logic [8:0]       out_blocks_in_use
);

  logic [12:0]    blk_size_r;
  logic [8:0]     blk_count_r;
  logic           cfg_wr;
  fbpa_pkg::cfg_t cfg;
  fbpa_pkg::res_t res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_size_r  <= fbpa_pkg::SIZE_RESET;
      blk_count_r <= fbpa_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == fbpa_pkg::REG_BLOCK_SIZE) begin
        blk_size_r <= cfg_pwdata[12:0];
      end else begin
        blk_count_r <= cfg_pwdata[8:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == fbpa_pkg::REG_BLOCK_COUNT) ? 32'(blk_count_r)
                                                                  : 32'(blk_size_r);

  assign cfg.eff_size    = fbpa_pkg::eff_size(blk_size_r);
  assign cfg.block_count = blk_count_r;

  fbpa_core #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_request_size (in_request_size),
    .in_free_index   (in_free_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_res         (res)
  );

  assign out_status        = res.status;
  assign out_block_index   = res.block_index;
  assign out_byte_offset   = res.byte_offset;
  assign out_blocks_in_use = res.blocks_in_use;

  `FBPA_ASSERT_NOW(a_relink_after_reset, !$past(rst_n), !in_ready, "item taken during relink")
  `FBPA_ASSERT_NEXT(a_pool_reset_blocks, in_valid && in_ready && in_mode == fbpa_pkg::MODE_RESET, !in_ready, "pool reset did not start relink")
  `FBPA_ASSERT_NOW(a_fail_zero_fields, out_valid && out_status != fbpa_pkg::ST_OK, out_block_index == 8'd0 && out_byte_offset == 20'd0, "failed allocate carries a block")

endmodule
`default_nettype wire

// ----- dv/fixed_block_pool_allocator_tb.sv -----
// Self-checking testbench for the fixed block pool allocator
`timescale 1ns / 1ps
module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int NUM_BLOCKS     = DEF_NUM_BLOCKS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [1:0]  in_mode = MODE_NOP;
  logic [15:0] in_request_size = '0;
  logic [7:0]  in_free_index = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [1:0]  out_status;
  wire  [7:0]  out_block_index;
  wire  [19:0] out_byte_offset;
  wire  [8:0]  out_blocks_in_use;

  fixed_block_pool_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_request_size(in_request_size), .in_free_index(in_free_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_block_index(out_block_index), .out_byte_offset(out_byte_offset),
    .out_blocks_in_use(out_blocks_in_use)
  );

  always #1 clk = ~clk;

  // shadow of the pool: registers, free list and count
  logic [12:0] size_reg;
  logic [8:0]  count_reg;
  logic [8:0]  link_mem [256];
  logic        link_ok [256];
  logic [8:0]  head;
  logic        head_ok;
  logic [8:0]  used;
  logic [8:0]  pool_size;

  res_t       pool_replies [$];
  logic [7:0] held_blocks [$];

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int hold_left = 0;
  int fault_count = 0;
  int quiet_cycles = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_settings = 0;
  int n_alloc_ok = 0;
  int n_too_big = 0;
  int n_empty = 0;
  int n_relinks = 0;

  function automatic logic [12:0] size_in_effect();
    logic [12:0] s;
    s = size_reg;
    if (s == 13'd0) s = 13'd1;
    else if (s > SIZE_LIMIT) s = SIZE_LIMIT;
    return s;
  endfunction

  function automatic void relink_pool();
    int n;
    n = int'(count_reg);
    if (n == 0) n = 1;
    if (n > NUM_BLOCKS) n = NUM_BLOCKS;
    if (n > 256) n = 256;
    pool_size = 9'(n);
    for (int i = 0; i < 256; i++) begin
      link_mem[i] = (i + 1 < n) ? 9'(i + 1) : 9'd0;
      link_ok[i]  = (i + 1 < n);
    end
    head    = '0;
    head_ok = 1'b1;
    used    = '0;
  endfunction

  function automatic res_t pool_step(input mode_t mode, input logic [15:0] req,
                                     input logic [7:0] fidx);
    res_t        r;
    logic [12:0] bsz;
    logic [7:0]  idx;
    bsz = size_in_effect();
    r.status        = ST_OK;
    r.block_index   = '0;
    r.byte_offset   = '0;
    case (mode)
      MODE_ALLOC: begin
        if (req > bsz) begin
          r.status = ST_TOO_BIG;
        end else if (!head_ok || head >= pool_size) begin
          r.status = ST_EMPTY;
        end else begin
          idx           = head[7:0];
          r.block_index = idx;
          r.byte_offset = 20'(idx) * 20'(bsz);
          head_ok       = link_ok[idx];
          head          = link_mem[idx];
          if (used < 9'd256) used = used + 9'd1;
        end
      end
      MODE_FREE: begin
        r.block_index = fidx;
        r.byte_offset = 20'(fidx) * 20'(bsz);
        // indices outside the pool leave list and count alone
        if (fidx < pool_size) begin
          link_mem[fidx] = head;
          link_ok[fidx]  = head_ok;
          head           = {1'b0, fidx};
          head_ok        = 1'b1;
          if (used > 9'd0) used = used - 9'd1;
        end
      end
      MODE_RESET: relink_pool();
      default: ;
    endcase
    r.blocks_in_use = used;
    return r;
  endfunction

  // result check and receiver back-pressure
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (pool_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: result with nothing pending: st=%0d idx=%0d off=%0d use=%0d",
                   $time, out_status, out_block_index, out_byte_offset, out_blocks_in_use);
      end else begin
        want = pool_replies.pop_front();
        if (out_status !== want.status || out_block_index !== want.block_index ||
            out_byte_offset !== want.byte_offset ||
            out_blocks_in_use !== want.blocks_in_use) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: mismatch exp st=%0d idx=%0d off=%0d use=%0d",
                     $time, want.status, want.block_index, want.byte_offset,
                     want.blocks_in_use,
                     " got st=%0d idx=%0d off=%0d use=%0d",
                     out_status, out_block_index, out_byte_offset, out_blocks_in_use);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input mode_t mode, input logic [15:0] req, input logic [7:0] fidx);
    res_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_request_size <= req;
    in_free_index   <= fidx;
    do @(posedge clk); while (!in_ready);
    r = pool_step(mode, req, fidx);
    pool_replies.push_back(r);
    n_items++;
    if (mode == MODE_RESET) begin
      held_blocks.delete();
      n_relinks++;
    end else if (mode == MODE_ALLOC) begin
      case (r.status)
        ST_OK: begin
          held_blocks.push_back(r.block_index);
          n_alloc_ok++;
        end
        ST_TOO_BIG: n_too_big++;
        default: n_empty++;
      endcase
    end
  endtask

  // drop valid and drain everything in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pool_replies.size() != 0) @(posedge clk);
  endtask

  task automatic program_pool(input logic [12:0] size, input logic [8:0] count);
    logic [31:0] word;
    wait_idle();
    for (int k = 0; k < 2; k++) begin
      word = $urandom;
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      if (k == 0) begin
        word[12:0] = size;
        cfg_paddr <= {REG_BLOCK_SIZE, 2'b00};
        size_reg = size;
      end else begin
        word[8:0] = count;
        cfg_paddr <= {REG_BLOCK_COUNT, 2'b00};
        count_reg = count;
      end
      cfg_pwdata <= word;
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(input int count);
    int          pick;
    int          pos;
    int          alloc_pct;
    logic [1:0]  m;
    logic [15:0] req;
    logic [7:0]  fidx;
    alloc_pct = 60;
    for (int n = 0; n < count; n++) begin
      // swing between filling and draining the pool
      if (n % 40 == 0) alloc_pct = (alloc_pct == 60) ? 30 : 60;
      pick = $urandom_range(99);
      req  = 16'($urandom);
      fidx = 8'($urandom);
      if (pick < 2) begin
        send_item(MODE_RESET, req, fidx);
      end else if (pick < 5) begin
        m = 2'($urandom_range(3));
        send_item(mode_t'(m), req, fidx);
      end else if (pick < 5 + alloc_pct) begin
        case ($urandom_range(9))
          0: ;
          1: req = 16'(size_in_effect()) + 16'd1;
          default: req = 16'($urandom_range(size_in_effect()));
        endcase
        send_item(MODE_ALLOC, req, fidx);
      end else begin
        if (held_blocks.size() > 0 && $urandom_range(9) != 0) begin
          pos  = $urandom_range(held_blocks.size() - 1);
          fidx = held_blocks[pos];
          held_blocks.delete(pos);
        end
        send_item(MODE_FREE, req, fidx);
      end
    end
  endtask

  task automatic test_directed();
    program_pool(13'd64, 9'd4);
    // count write waits for the next relink
    send_item(MODE_ALLOC, 16'd0, 8'd0);
    send_item(MODE_FREE, 16'd0, 8'd255);
    send_item(MODE_RESET, 16'hFFFF, 8'hFF);
    send_item(MODE_ALLOC, 16'd64, 8'd0);
    send_item(MODE_ALLOC, 16'd65, 8'd0);
    send_item(MODE_ALLOC, 16'hFFFF, 8'd0);
    send_item(MODE_ALLOC, 16'd1, 8'd0);
    send_item(MODE_ALLOC, 16'd2, 8'd0);
    send_item(MODE_ALLOC, 16'd3, 8'd0);
    send_item(MODE_ALLOC, 16'd0, 8'd0);
    send_item(MODE_FREE, 16'd0, 8'hFF);
    send_item(MODE_FREE, 16'd0, 8'd2);
    send_item(MODE_ALLOC, 16'd8, 8'd0);
    send_item(MODE_NOP, 16'hFFFF, 8'hFF);
    send_item(MODE_FREE, 16'd0, 8'd1);
    send_item(MODE_FREE, 16'd0, 8'd1);
    send_item(MODE_ALLOC, 16'd0, 8'd0);
    send_item(MODE_ALLOC, 16'd0, 8'd0);
    send_item(MODE_ALLOC, 16'd0, 8'd0);
    send_item(MODE_RESET, 16'd0, 8'd0);
    send_item(MODE_FREE, 16'd0, 8'd0);
    send_item(MODE_ALLOC, 16'd0, 8'd0);
  endtask

  task automatic test_config_sweep();
    logic [12:0] sizes [7];
    logic [8:0]  counts [7];
    sizes  = '{13'd0, 13'd1, 13'd4096, 13'd4097, 13'd8191, 13'd100, 13'd7};
    counts = '{9'd0, 9'd1, 9'd256, 9'd257, 9'd511, 9'd3, 9'd17};
    for (int k = 0; k < 7; k++) begin
      program_pool(sizes[k], counts[k]);
      send_item(MODE_RESET, 16'd0, 8'd0);
      run_random(60);
    end
  endtask

  // hold the receiver off while items keep coming
  task automatic test_backpressure();
    program_pool(13'd64, 9'd256);
    send_item(MODE_RESET, 16'd0, 8'd0);
    hold_left <= HOLD_CYCLES;
    run_random(60);
    run_random(250);
  endtask

  // one-block pool looped on itself by a double free, allocated past 256
  task automatic test_count_saturation();
    program_pool(13'd1, 9'd1);
    send_item(MODE_RESET, 16'd0, 8'd0);
    send_item(MODE_FREE, 16'd0, 8'd0);
    send_item(MODE_FREE, 16'd0, 8'd0);
    for (int n = 0; n < 258; n++) send_item(MODE_ALLOC, 16'($urandom_range(1)), 8'd0);
    send_item(MODE_FREE, 16'd0, 8'd0);
    send_item(MODE_ALLOC, 16'd2, 8'd0);
  endtask

  task automatic test_random_tail();
    program_pool(13'd2048, 9'd8);
    send_item(MODE_RESET, 16'd0, 8'd0);
    run_random(250);
  endtask

  initial begin
    size_reg  = SIZE_RESET;
    count_reg = COUNT_RESET;
    relink_pool();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // wait out the relink after reset
    do @(posedge clk); while (!in_ready);

    send_gap_pct = 28;
    recv_gap_pct = 57;
    test_directed();
    test_config_sweep();

    send_gap_pct = 57;
    recv_gap_pct = 28;
    test_backpressure();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_count_saturation();
    test_random_tail();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items over %0d pool settings, %0d results checked",
             n_items, n_settings, n_checked);
    $display("grants %0d, oversize %0d, pool empty %0d, pool relinks %0d, faults %0d",
             n_alloc_ok, n_too_big, n_empty, n_relinks, fault_count);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
